>>> design/cc20_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg: shared types and constants for the chacha20 stream core
// Word and block types, command format, register indexes and the
// half quarter-round used by the block generator.
// ----------------------------------------------------------------------------
package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] block_t;

	// "expand 32-byte k"
	localparam word_t SIGMA_0 = 32'h6170_7865;
	localparam word_t SIGMA_1 = 32'h3320_646e;
	localparam word_t SIGMA_2 = 32'h7962_2d32;
	localparam word_t SIGMA_3 = 32'h6b20_6574;

	localparam int unsigned ROT_A = 16;
	localparam int unsigned ROT_B = 12;
	localparam int unsigned ROT_C = 8;
	localparam int unsigned ROT_D = 7;

	// 10 double rounds, each double round is four half quarter-round steps
	localparam int unsigned DOUBLE_ROUNDS = 10;
	localparam int unsigned HALF_STEPS    = 4 * DOUBLE_ROUNDS;
	localparam int unsigned STEP_W        = $clog2(HALF_STEPS);
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t LAST_STEP = step_t'(HALF_STEPS - 1);

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned BIDX_W      = $clog2(BLOCK_BYTES);
	typedef logic [BIDX_W-1:0] bidx_t;
	typedef logic [BIDX_W:0]   pos_t;
	localparam pos_t POS_USED_UP = pos_t'(BLOCK_BYTES);

	// word queues between the parts
	localparam int unsigned CMDQ_DEPTH = 4;
	localparam int unsigned OUTQ_DEPTH = 4;

	// configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_KEY_BYTES_0_7    = 3'd0;
	localparam cfg_idx_t CFG_KEY_BYTES_8_15   = 3'd1;
	localparam cfg_idx_t CFG_KEY_BYTES_16_23  = 3'd2;
	localparam cfg_idx_t CFG_KEY_BYTES_24_31  = 3'd3;
	localparam cfg_idx_t CFG_NONCE_BYTES_0_7  = 3'd4;
	localparam cfg_idx_t CFG_NONCE_BYTES_8_11 = 3'd5;

	typedef struct packed {
		logic [7:0][31:0] key;
		logic [2:0][31:0] nonce;
	} cfg_t;

	// one classified input word for the back end
	typedef struct packed {
		logic [7:0] data;
		bidx_t      idx;
		logic       new_blk;
		word_t      ctr;
	} cmd_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// first or second half of a quarter round
	function automatic quad_t half_qr(input quad_t q, input logic second);
		quad_t r;
		word_t t;
		r = q;
		r.a = q.a + q.b;
		t = q.d ^ r.a;
		r.d = second ? rotl(t, ROT_C) : rotl(t, ROT_A);
		r.c = q.c + r.d;
		t = q.b ^ r.c;
		r.b = second ? rotl(t, ROT_D) : rotl(t, ROT_B);
		return r;
	endfunction

endpackage

>>> design/cc20_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_front: input side of the chacha20 stream core
// Tracks keystream position and block counter, tags each byte with its
// keystream index or a new-block request, and queues it for the back end.
// ----------------------------------------------------------------------------
module cc20_front import cc20_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] data_byte,
	input  logic       restart,
	output logic       full,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_pop
);

	localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

	pos_t             pos_q;
	word_t            ctr_q;
	cmd_t             q_mem [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             pop_ok;
	cmd_t             cmd_in;

	assign full      = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign accept    = push && !full;
	assign pop_ok    = cmd_pop && cmd_valid;
	assign cmd       = q_mem[rd_q];

	// restart forces a fresh block with counter zero
	always_comb begin
		cmd_in.data    = data_byte;
		cmd_in.new_blk = restart || (pos_q == POS_USED_UP);
		cmd_in.idx     = cmd_in.new_blk ? '0 : pos_q[BIDX_W-1:0];
		cmd_in.ctr     = restart ? '0 : ctr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_USED_UP;
			ctr_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wr_q <= wr_q + 1'b1;
				if (cmd_in.new_blk) begin
					ctr_q <= cmd_in.ctr + 32'd1;
					pos_q <= pos_t'(1);
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (pop_ok) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(accept) - CNT_W'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[wr_q] <= cmd_in;
		end
	end

endmodule

>>> design/cc20_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_block: iterative chacha20 block generator
// Runs four half quarter-rounds in parallel per cycle, 40 steps for the
// 20 rounds, then adds the input words back.
// ----------------------------------------------------------------------------
module cc20_block import cc20_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  cfg_t   cfg,
	input  word_t  ctr,
	output logic   done,
	output block_t ks
);

	logic   busy_q;
	logic   done_q;
	step_t  step_q;
	block_t w_q;
	block_t init_q;
	block_t init_d;
	block_t nxt;

	always_comb begin
		init_d[0]  = SIGMA_0;
		init_d[1]  = SIGMA_1;
		init_d[2]  = SIGMA_2;
		init_d[3]  = SIGMA_3;
		for (int i = 0; i < 8; i++) begin
			init_d[4 + i] = cfg.key[i];
		end
		init_d[12] = ctr;
		for (int i = 0; i < 3; i++) begin
			init_d[13 + i] = cfg.nonce[i];
		end
	end

	// step bit 0: which half, bit 1: column or diagonal round
	always_comb begin
		int    ib;
		int    ic;
		int    id;
		int    sh;
		quad_t q;
		quad_t r;
		nxt = w_q;
		sh  = step_q[1] ? 1 : 0;
		for (int l = 0; l < 4; l++) begin
			ib  = 4 + ((l + sh) & 3);
			ic  = 8 + ((l + 2 * sh) & 3);
			id  = 12 + ((l + 3 * sh) & 3);
			q.a = w_q[l];
			q.b = w_q[ib];
			q.c = w_q[ic];
			q.d = w_q[id];
			r   = half_qr(q, step_q[0]);
			nxt[l]  = r.a;
			nxt[ib] = r.b;
			nxt[ic] = r.c;
			nxt[id] = r.d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			init_q <= init_d;
			w_q    <= init_d;
		end else if (busy_q) begin
			w_q <= nxt;
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			ks[i] = w_q[i] + init_q[i];
		end
	end

	assign done = done_q;

endmodule

>>> design/cc20_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_back: execution side of the chacha20 stream core
// Starts block generation when a word asks for it, holds the keystream
// block, xors each byte and queues results.
// ----------------------------------------------------------------------------
module cc20_back import cc20_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       blk_start,
	output word_t      blk_ctr,
	input  logic       blk_done,
	input  block_t     blk_ks,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] result_byte
);

	localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);
	localparam int unsigned CNT_W = $clog2(OUTQ_DEPTH + 1);

	typedef enum logic {
		ST_RUN,
		ST_GEN
	} state_t;

	state_t           state_q;
	logic             made_q;
	logic             start_q;
	block_t           ks_q;
	logic       [7:0] oq_mem [OUTQ_DEPTH];
	logic [PTR_W-1:0] owr_q;
	logic [PTR_W-1:0] ord_q;
	logic [CNT_W-1:0] ocnt_q;
	logic             oq_full;
	logic             pop_ok;
	logic       [7:0] ks_byte;
	logic             need_blk;

	assign oq_full     = (ocnt_q == CNT_W'(OUTQ_DEPTH));
	assign empty       = (ocnt_q == '0);
	assign pop_ok      = pop && !empty;
	assign result_byte = oq_mem[ord_q];
	assign blk_start   = start_q;
	assign blk_ctr     = cmd.ctr;

	assign need_blk = cmd_valid && cmd.new_blk && !made_q;
	assign cmd_pop  = (state_q == ST_RUN) && cmd_valid
		&& (!cmd.new_blk || made_q) && !oq_full;
	assign ks_byte  = ks_q[cmd.idx[BIDX_W-1:2]][{cmd.idx[1:0], 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			made_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_RUN: begin
					if (need_blk) begin
						state_q <= ST_GEN;
						start_q <= 1'b1;
					end else if (cmd_pop) begin
						made_q <= 1'b0;
					end
				end
				ST_GEN: begin
					if (blk_done) begin
						state_q <= ST_RUN;
						made_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (blk_done) begin
			ks_q <= blk_ks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (cmd_pop) begin
				owr_q <= owr_q + 1'b1;
			end
			if (pop_ok) begin
				ord_q <= ord_q + 1'b1;
			end
			ocnt_q <= ocnt_q + CNT_W'(cmd_pop) - CNT_W'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			oq_mem[owr_q] <= cmd.data ^ ks_byte;
		end
	end

endmodule

>>> design/chacha20_stream_xor_core.sv
`timescale 1ns / 1ps
// a byte within a ready block is registered in the command queue, then in the result queue
// a byte that opens a new block waits for the start pulse, 40 round steps, add and latch
// throughput: one byte per cycle inside a block while the result queue has room; block generation of 40 round steps
// in cc20_block stalls the back end once every 64 bytes and after each restart
// reset: arst_n clears key, nonce, counter and queues; the keystream is marked used up
// ----------------------------------------------------------------------------
// chacha20_stream_xor_core: chacha20 (ietf layout) byte stream xor
// Front end classifies input words, a command queue decouples it from the
// back end, which generates keystream blocks and xors data bytes.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_core import cc20_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input word queue
	input  logic        push,
	output logic        full,
	input  logic  [7:0] data_byte,
	input  logic        restart,
	// result word queue
	output logic        empty,
	input  logic        pop,
	output logic  [7:0] result_byte,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [63:0] cfg_data
);

	// configuration registers, key and nonce little-endian words
	logic [3:0][63:0] key_q;
	logic     [63:0]  nonce_lo_q;
	logic     [31:0]  nonce_hi_q;
	cfg_t             cfg;

	// front to back command queue
	logic   cmd_valid;
	cmd_t   cmd;
	logic   cmd_pop;

	// block generator handshake
	logic   blk_start;
	word_t  blk_ctr;
	logic   blk_done;
	block_t blk_ks;

	// writes are always taken at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KEY_BYTES_0_7:    key_q[0]   <= cfg_data;
				CFG_KEY_BYTES_8_15:   key_q[1]   <= cfg_data;
				CFG_KEY_BYTES_16_23:  key_q[2]   <= cfg_data;
				CFG_KEY_BYTES_24_31:  key_q[3]   <= cfg_data;
				CFG_NONCE_BYTES_0_7:  nonce_lo_q <= cfg_data;
				CFG_NONCE_BYTES_8_11: nonce_hi_q <= cfg_data[31:0];
				default: begin
					// indexes past the list are ignored
				end
			endcase
		end
	end

	// split the 64-bit registers into state words
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cfg.key[2 * i]     = key_q[i][31:0];
			cfg.key[2 * i + 1] = key_q[i][63:32];
		end
		cfg.nonce[0] = nonce_lo_q[31:0];
		cfg.nonce[1] = nonce_lo_q[63:32];
		cfg.nonce[2] = nonce_hi_q;
	end

	// front: position and counter tracking plus command queue
	cc20_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.restart   (restart),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: keystream holding, xor and result queue
	cc20_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.blk_start   (blk_start),
		.blk_ctr     (blk_ctr),
		.blk_done    (blk_done),
		.blk_ks      (blk_ks),
		.empty       (empty),
		.pop         (pop),
		.result_byte (result_byte)
	);

	// single round engine, started by the back end
	cc20_block u_block (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blk_start),
		.cfg    (cfg),
		.ctr    (blk_ctr),
		.done   (blk_done),
		.ks     (blk_ks)
	);

`ifndef ASSERT_OFF
	// an accepted word is in the command queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> cmd_valid)
		else $error("accepted word missing from command queue");

	// a block start is a single pulse
	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		blk_start |=> !blk_start)
		else $error("block start held for more than one cycle");

	// a start never overlaps the end of a previous block
	a_start_vs_done: assert property (@(posedge clk) disable iff (!arst_n)
		blk_start |-> !blk_done)
		else $error("block start while a block completes");

	// no byte leaves the command queue in the cycle its block completes
	a_no_pop_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		blk_done |-> !cmd_pop)
		else $error("command popped during block generation");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the chacha20 stream xor core
// Drives byte words and restart flags through the input queue and programs
// key and nonce between phases. A local keystream generator predicts every
// result word, and a checker compares the result queue against it in order.
// ----------------------------------------------------------------------------
module tb_top;
	import cc20_pkg::*;

	// run control
	localparam int unsigned IDLE_PCT      = 9;     // idle odds per cycle, both sides
	localparam int unsigned HOLD_CYCLES   = 400;   // long receiver hold-off
	localparam int unsigned STALL_LIMIT   = 5000;  // cycles with no handshake at all
	localparam int unsigned SETTLE_CYCLES = 60;    // covers one block generation
	localparam int unsigned SHOW_MAX      = 10;
	localparam int unsigned PHASES        = 7;

	// "expand 32-byte k", kept locally for the predictor
	localparam logic [31:0] EXPAND_0 = 32'h6170_7865;
	localparam logic [31:0] EXPAND_1 = 32'h3320_646e;
	localparam logic [31:0] EXPAND_2 = 32'h7962_2d32;
	localparam logic [31:0] EXPAND_3 = 32'h6b20_6574;

	// indexes past the last register, writes there must be dropped
	localparam cfg_idx_t CFG_SPARE_6 = 3'd6;
	localparam cfg_idx_t CFG_SPARE_7 = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic  [7:0] data_byte;
	logic        restart;
	logic        empty;
	logic        pop;
	logic  [7:0] result_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	logic [63:0] cfg_data;

	// shadow of the key and nonce registers
	logic [63:0] key_sh [4];
	logic [63:0] nonce_sh_lo;
	logic [31:0] nonce_sh_hi;

	// keystream state of the predictor
	logic [31:0] blk_ctr;
	pos_t        ks_pos;
	logic  [7:0] ks_bytes [64];
	logic [31:0] mix_w [16];

	// expected result words, oldest first
	logic  [7:0] cipher_q [$];
	logic  [7:0] want;
	int unsigned bad_bytes;
	int unsigned stall_cnt;

	// both sides run without idling while set
	bit quiet;
	// asks the receiver for one long hold-off
	bit hold_req;

	chacha20_stream_xor_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.restart     (restart),
		.empty       (empty),
		.pop         (pop),
		.result_byte (result_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// keystream predictor
	// ------------------------------------------------------------------

	function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// one full quarter round on the working state
	function automatic void qround(input int a, input int b, input int c, input int d);
		mix_w[a] = mix_w[a] + mix_w[b];
		mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 16);
		mix_w[c] = mix_w[c] + mix_w[d];
		mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 12);
		mix_w[a] = mix_w[a] + mix_w[b];
		mix_w[d] = rol32(mix_w[d] ^ mix_w[a], 8);
		mix_w[c] = mix_w[c] + mix_w[d];
		mix_w[b] = rol32(mix_w[b] ^ mix_w[c], 7);
	endfunction

	// advances the stream by one byte and returns the expected result word
	function automatic logic [7:0] xor_keystream(input logic [7:0] d, input logic rs);
		logic [31:0] init_w [16];
		logic [31:0] sum;
		logic  [7:0] ks;
		// restart drops the rest of the block and rewinds the counter
		if (rs) begin
			blk_ctr = '0;
			ks_pos  = POS_USED_UP;
		end
		if (ks_pos >= POS_USED_UP) begin
			init_w[0] = EXPAND_0;
			init_w[1] = EXPAND_1;
			init_w[2] = EXPAND_2;
			init_w[3] = EXPAND_3;
			// key words are little-endian, low half of each register first
			for (int i = 0; i < 4; i++) begin
				init_w[4 + 2 * i] = key_sh[i][31:0];
				init_w[5 + 2 * i] = key_sh[i][63:32];
			end
			init_w[12] = blk_ctr;
			init_w[13] = nonce_sh_lo[31:0];
			init_w[14] = nonce_sh_lo[63:32];
			init_w[15] = nonce_sh_hi;
			mix_w = init_w;
			for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
				// column rounds
				qround(0, 4, 8, 12);
				qround(1, 5, 9, 13);
				qround(2, 6, 10, 14);
				qround(3, 7, 11, 15);
				// diagonal rounds
				qround(0, 5, 10, 15);
				qround(1, 6, 11, 12);
				qround(2, 7, 8, 13);
				qround(3, 4, 9, 14);
			end
			// feed-forward, then serialize little-endian
			for (int i = 0; i < 16; i++) begin
				sum = mix_w[i] + init_w[i];
				ks_bytes[4 * i]     = sum[7:0];
				ks_bytes[4 * i + 1] = sum[15:8];
				ks_bytes[4 * i + 2] = sum[23:16];
				ks_bytes[4 * i + 3] = sum[31:24];
			end
			// counter wraps mod 2^32; reaching that needs 2^32 blocks, out of reach here
			blk_ctr = blk_ctr + 32'd1;
			ks_pos  = '0;
		end
		ks = ks_bytes[ks_pos[BIDX_W-1:0]];
		ks_pos = ks_pos + pos_t'(1);
		return d ^ ks;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// ------------------------------------------------------------------
	// drivers, all entered and left at a falling edge
	// ------------------------------------------------------------------

	// one byte word into the input queue; push stays high for the next word
	task automatic send_word(input logic [7:0] d, input logic rs);
		// random one-cycle gap before this word
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			push = 1'b0;
			@(negedge clk);
		end
		push      = 1'b1;
		data_byte = d;
		restart   = rs;
		do @(posedge clk); while (full);
		// accepted at this edge
		cipher_q.push_back(xor_keystream(d, rs));
		@(negedge clk);
	endtask

	// sender pauses until every expected word has come back
	task automatic drain();
		push = 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// one register write; cfg_valid is lowered by the caller after the last one
	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_KEY_BYTES_0_7:    key_sh[0]   = v;
			CFG_KEY_BYTES_8_15:   key_sh[1]   = v;
			CFG_KEY_BYTES_16_23:  key_sh[2]   = v;
			CFG_KEY_BYTES_24_31:  key_sh[3]   = v;
			CFG_NONCE_BYTES_0_7:  nonce_sh_lo = v;
			CFG_NONCE_BYTES_8_11: nonce_sh_hi = v[31:0];
			default: ;  // out of range, dropped
		endcase
		@(negedge clk);
	endtask

	// programs key and nonce, optionally with junk writes to unused indexes
	task automatic program_regs(input logic [63:0] k0, input logic [63:0] k1,
		input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] n0,
		input logic [63:0] n1, input bit spare);
		write_reg(CFG_KEY_BYTES_0_7, k0);
		write_reg(CFG_KEY_BYTES_8_15, k1);
		if (spare) begin
			write_reg(CFG_SPARE_6, rand64());
		end
		write_reg(CFG_KEY_BYTES_16_23, k2);
		write_reg(CFG_KEY_BYTES_24_31, k3);
		write_reg(CFG_NONCE_BYTES_0_7, n0);
		if (spare) begin
			write_reg(CFG_SPARE_7, rand64());
		end
		write_reg(CFG_NONCE_BYTES_8_11, n1);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// pop policy, decided at each falling edge
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold-off so the core backs up and raises full
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				pop = quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// compare each popped word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (cipher_q.size() == 0) begin
				bad_bytes++;
				if (bad_bytes <= SHOW_MAX)
					$display("unexpected result word: got %02h", result_byte);
			end else begin
				want = cipher_q.pop_front();
				if (result_byte !== want) begin
					bad_bytes++;
					if (bad_bytes <= SHOW_MAX)
						$display("result_byte: expected %02h, got %02h", want, result_byte);
				end
			end
		end
	end

	// ends a hung run: no handshake on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// zero key and nonce out of reset, restart on a used-up block,
	// restart mid-block and two restarts back to back
	task automatic test_reset_state();
		send_word(8'h00, 1'b1);
		send_word(8'hff, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'ha5, 1'b1);
		send_word(8'h5a, 1'b1);
		send_word(8'h7f, 1'b0);
		drain();
	endtask

	// all-ones registers (nonce high gets a full 64-bit word, upper half dropped)
	// with junk writes to unused indexes, then back to all zeros
	task automatic test_config_extremes();
		program_regs('1, '1, '1, '1, '1, '1, 1'b1);
		send_word(8'h00, 1'b1);
		send_word(8'hff, 1'b0);
		send_word(8'h3c, 1'b0);
		drain();
		program_regs('0, '0, '0, '0, '0, '0, 1'b1);
		send_word(8'hc3, 1'b1);
		send_word(8'h69, 1'b0);
		drain();
	endtask

	// new key without restart: the current block keeps going with the old key
	task automatic test_mid_stream_write();
		program_regs(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
			64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
			64'h4a00_0000_0900_0000, 64'h0000_0000, 1'b0);
		send_word(8'h11, 1'b1);
		send_word(8'h22, 1'b0);
		send_word(8'h33, 1'b0);
		drain();
		program_regs(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), 1'b0);
		send_word(8'h44, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(8'h66, 1'b0);
		drain();
	endtask

	// long random streams, a fresh setting per phase; one phase without idling,
	// one phase with a long receiver hold-off while the sender keeps pushing
	task automatic test_random_streams();
		int unsigned n_words;
		for (int p = 0; p < PHASES; p++) begin
			if (p == 1)
				program_regs('1, '1, '1, '1, '1, '1, 1'b0);
			else if (p == 5)
				program_regs('0, '0, '0, '0, '0, '0, 1'b1);
			else
				program_regs(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
					($urandom_range(1) == 1));
			quiet = (p == 2);
			if (p == 4)
				hold_req = 1'b1;
			n_words = $urandom_range(180, 300);
			// first word may continue the old stream under the new key
			send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
			for (int i = 1; i < n_words; i++) begin
				send_word(8'($urandom_range(255)), ($urandom_range(99) < 2));
			end
			drain();
			quiet = 1'b0;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		data_byte   = '0;
		restart     = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_KEY_BYTES_0_7;
		cfg_data    = '0;
		quiet       = 1'b0;
		hold_req    = 1'b0;
		bad_bytes   = 0;
		stall_cnt   = 0;
		foreach (key_sh[i]) key_sh[i] = '0;
		nonce_sh_lo = '0;
		nonce_sh_hi = '0;
		blk_ctr     = '0;
		ks_pos      = POS_USED_UP;
		foreach (ks_bytes[i]) ks_bytes[i] = '0;

		// reset held from the start, released at a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_config_extremes();
		test_mid_stream_write();
		test_random_streams();

		// everything returned; watch a little longer for stray words
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_bytes == 0 && cipher_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
